// ===== rtl/core/lsd_pkg.sv =====
// Shared types and constants for the LED driver shift sequencer.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package lsd_pkg;

  // Field widths of the input beat, the result beat and the registers.
  localparam int LED_W   = 5;
  localparam int TICK_W  = 16;
  localparam int LONG_W  = 24;
  localparam int REPS_W  = 4;

  // Configuration port geometry.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Data line positions: on at 31-led and 21-led, off one bit later.
  localparam logic signed [7:0] DATA_ON_A  = 8'sd31;
  localparam logic signed [7:0] LED_STRIDE = 8'sd10;
  localparam logic signed [7:0] DATA_ON_B  = DATA_ON_A - LED_STRIDE;
  localparam logic signed [7:0] DATA_OFF_A = DATA_ON_A + 8'sd1;
  localparam logic signed [7:0] DATA_OFF_B = DATA_ON_B + 8'sd1;

  // Register reset values.
  localparam logic [TICK_W-1:0] CLK_HIGH_RST  = 16'd5000;
  localparam logic [TICK_W-1:0] CLK_LOW_RST   = 16'd5000;
  localparam logic [TICK_W-1:0] LE_TO_OE_RST  = 16'd10;
  localparam logic [LONG_W-1:0] GAP_RST       = 24'd10;
  localparam logic [REPS_W-1:0] REPEATS_RST   = 4'd10;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_CLK_HIGH    = 3'd0,
    REG_CLK_LOW     = 3'd1,
    REG_LE_TO_OE    = 3'd2,
    REG_GAP         = 3'd3,
    REG_SCAN_REPS   = 3'd4
  } reg_idx_t;

  // Sequencer phases, one-hot.
  typedef enum logic [8:0] {
    PH_IDLE     = 9'b000000001,
    PH_BIT_LOW  = 9'b000000010,
    PH_BIT_HIGH = 9'b000000100,
    PH_CLK_END  = 9'b000001000,
    PH_LE_HIGH  = 9'b000010000,
    PH_LE_LOW   = 9'b000100000,
    PH_OE_LOW   = 9'b001000000,
    PH_NEXT     = 9'b010000000,
    PH_FINISH   = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [TICK_W-1:0] clock_high_ticks;
    logic [TICK_W-1:0] clock_low_ticks;
    logic [TICK_W-1:0] latch_to_enable_ticks;
    logic [LONG_W-1:0] gap_ticks;
    logic [REPS_W-1:0] scan_repeats;
  } cfg_t;

  typedef struct packed {
    logic              op;
    logic [LED_W-1:0]  led_index;
    logic [LONG_W-1:0] oe_low_ticks;
    logic              repeat_mode;
    logic              in_cradle;
  } in_item_t;

  typedef struct packed {
    logic clk_pin;
    logic data_pin;
    logic latch_pin;
    logic enable_pin;
    logic busy_res;
    logic done_res;
    logic completed_ok;
  } out_item_t;

  // Sequencer state apart from the bit counter, whose width is a parameter.
  typedef struct packed {
    phase_t            phase;
    logic [REPS_W-1:0] repeat_count;
    logic [LONG_W-1:0] wait_counter;
    logic [LED_W-1:0]  saved_led;
    logic [LONG_W-1:0] saved_oe_time;
    logic              saved_scan;
    logic              pin_clk;
    logic              pin_data;
    logic              pin_le;
    logic              pin_oe;
  } seq_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/lsd_if.sv =====
// Valid/ready channel interfaces for command beats and pin-level result beats.
// Depends on lsd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lsd_in_if;
  import lsd_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [LED_W-1:0]  led_index;
  logic [LONG_W-1:0] oe_low_ticks;
  logic              repeat_mode;
  logic              in_cradle;

  modport source (output valid, op, led_index, oe_low_ticks, repeat_mode, in_cradle,
                  input ready);
  modport sink (input valid, op, led_index, oe_low_ticks, repeat_mode, in_cradle,
                output ready);
endinterface

interface lsd_out_if;
  logic valid;
  logic ready;
  logic clk_pin;
  logic data_pin;
  logic latch_pin;
  logic enable_pin;
  logic busy_res;
  logic done_res;
  logic completed_ok;

  modport source (output valid, clk_pin, data_pin, latch_pin, enable_pin, busy_res,
                  done_res, completed_ok, input ready);
  modport sink (input valid, clk_pin, data_pin, latch_pin, enable_pin, busy_res,
                done_res, completed_ok, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lsd_cfg_regs.sv =====
// APB-style register bank holding the timing and repeat settings.
// Depends on lsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsd_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [lsd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [lsd_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [lsd_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                cfg_pready,
  output lsd_pkg::cfg_t                       cfg
);
  import lsd_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  // Write decode; addresses past the last register are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_CLK_HIGH:  cfg_nxt.clock_high_ticks      = cfg_pwdata[TICK_W-1:0];
        REG_CLK_LOW:   cfg_nxt.clock_low_ticks       = cfg_pwdata[TICK_W-1:0];
        REG_LE_TO_OE:  cfg_nxt.latch_to_enable_ticks = cfg_pwdata[TICK_W-1:0];
        REG_GAP:       cfg_nxt.gap_ticks             = cfg_pwdata[LONG_W-1:0];
        REG_SCAN_REPS: cfg_nxt.scan_repeats          = cfg_pwdata[REPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clock_high_ticks      <= CLK_HIGH_RST;
      cfg_r.clock_low_ticks       <= CLK_LOW_RST;
      cfg_r.latch_to_enable_ticks <= LE_TO_OE_RST;
      cfg_r.gap_ticks             <= GAP_RST;
      cfg_r.scan_repeats          <= REPEATS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux.
  always_comb begin
    unique case (idx)
      REG_CLK_HIGH:  cfg_prdata = CFG_DATA_W'(cfg_r.clock_high_ticks);
      REG_CLK_LOW:   cfg_prdata = CFG_DATA_W'(cfg_r.clock_low_ticks);
      REG_LE_TO_OE:  cfg_prdata = CFG_DATA_W'(cfg_r.latch_to_enable_ticks);
      REG_GAP:       cfg_prdata = CFG_DATA_W'(cfg_r.gap_ticks);
      REG_SCAN_REPS: cfg_prdata = CFG_DATA_W'(cfg_r.scan_repeats);
      default:       cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/lsd_step.sv =====
// Next-state logic of the sequencer: one tick or start beat in, one pin result out.
// Depends on lsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsd_step #(
  parameter int SHIFT_BITS = 32
) (
  input  wire lsd_pkg::cfg_t                      cfg,
  input  wire lsd_pkg::seq_state_t                st,
  input  wire logic [$clog2(SHIFT_BITS)-1:0]      bit_idx,
  input  wire lsd_pkg::in_item_t                  item,
  output lsd_pkg::seq_state_t                     st_nxt,
  output logic      [$clog2(SHIFT_BITS)-1:0]      bit_nxt,
  output lsd_pkg::out_item_t                      res
);
  import lsd_pkg::*;

  localparam int                BIT_W    = $clog2(SHIFT_BITS);
  localparam logic [BIT_W-1:0]  LAST_BIT = BIT_W'(SHIFT_BITS - 1);

  // A zero delay still costs one tick.
  function automatic logic [LONG_W-1:0] wait_of(input logic [LONG_W-1:0] d);
    return (d == '0) ? LONG_W'(1) : d;
  endfunction

  // Data line level after the clock-low action for bit b.
  function automatic logic data_level(input logic [BIT_W-1:0] b,
                                      input logic [LED_W-1:0] led,
                                      input logic             cur);
    logic signed [7:0] bs;
    logic signed [7:0] ls;
    bs = $signed({{(8 - BIT_W){1'b0}}, b});
    ls = $signed({{(8 - LED_W){1'b0}}, led});
    if (bs == DATA_ON_A - ls || bs == DATA_ON_B - ls) begin
      return 1'b1;
    end else if (bs == DATA_OFF_A - ls || bs == DATA_OFF_B - ls) begin
      return 1'b0;
    end else begin
      return cur;
    end
  endfunction

  seq_state_t        s;
  logic [BIT_W-1:0]  b;
  logic [LONG_W-1:0] wc;
  logic [REPS_W-1:0] reps;
  logic              start_rep;
  logic              do_bit_low;
  logic              done;
  logic              ok;

  always_comb begin
    s          = st;
    b          = bit_idx;
    wc         = '0;
    reps       = '0;
    start_rep  = 1'b0;
    do_bit_low = 1'b0;
    done       = 1'b0;
    ok         = 1'b0;

    if (st.phase == PH_IDLE) begin
      // A start beat latches its command; a tick while idle does nothing.
      if (item.op) begin
        s.saved_led     = item.led_index;
        s.saved_oe_time = item.oe_low_ticks;
        s.saved_scan    = item.repeat_mode;
        reps            = item.repeat_mode ? cfg.scan_repeats : REPS_W'(1);
        if (reps == '0) begin
          reps = REPS_W'(1);
        end
        s.repeat_count  = reps - REPS_W'(1);
        start_rep       = 1'b1;
      end
    end else begin
      wc = (st.wait_counter != '0) ? st.wait_counter - LONG_W'(1) : '0;
      s.wait_counter = wc;
      // The pending pin action fires once the delay has run out.
      if (wc == '0) begin
        unique case (st.phase)
          PH_BIT_LOW: begin
            do_bit_low = 1'b1;
          end
          PH_BIT_HIGH: begin
            s.pin_clk      = 1'b1;
            s.wait_counter = wait_of(LONG_W'(cfg.clock_high_ticks));
            if (bit_idx == LAST_BIT) begin
              s.phase = PH_CLK_END;
            end else begin
              b       = bit_idx + BIT_W'(1);
              s.phase = PH_BIT_LOW;
            end
          end
          PH_CLK_END: begin
            s.pin_clk      = 1'b0;
            s.wait_counter = wait_of(LONG_W'(cfg.clock_low_ticks));
            s.phase        = PH_LE_HIGH;
          end
          PH_LE_HIGH: begin
            s.pin_le       = 1'b1;
            s.wait_counter = wait_of(LONG_W'(cfg.clock_high_ticks));
            s.phase        = PH_LE_LOW;
          end
          PH_LE_LOW: begin
            s.pin_le       = 1'b0;
            s.wait_counter = wait_of(LONG_W'(cfg.latch_to_enable_ticks));
            s.phase        = PH_OE_LOW;
          end
          PH_OE_LOW: begin
            s.pin_oe       = 1'b0;
            s.wait_counter = wait_of(st.saved_oe_time);
            s.phase        = PH_NEXT;
          end
          PH_NEXT: begin
            if (st.repeat_count != '0) begin
              s.repeat_count = st.repeat_count - REPS_W'(1);
              start_rep      = 1'b1;
            end else if (st.saved_scan) begin
              s.pin_oe       = 1'b1;
              s.wait_counter = wait_of(cfg.gap_ticks);
              s.phase        = PH_FINISH;
            end else begin
              s.phase        = PH_IDLE;
              s.wait_counter = '0;
              done           = 1'b1;
              ok             = 1'b1;
            end
          end
          default: begin
            s.phase        = PH_IDLE;
            s.wait_counter = '0;
            done           = 1'b1;
            ok             = 1'b1;
          end
        endcase
      end
    end

    // Start of a repetition: the cradle flag aborts, else shift from bit zero.
    if (start_rep) begin
      if (item.in_cradle) begin
        s.phase        = PH_IDLE;
        s.wait_counter = '0;
        done           = 1'b1;
        ok             = 1'b0;
      end else begin
        b          = '0;
        do_bit_low = 1'b1;
      end
    end

    // Clock low, data line update, then wait for the rising clock.
    if (do_bit_low) begin
      s.pin_clk      = 1'b0;
      s.pin_data     = data_level(b, s.saved_led, s.pin_data);
      s.wait_counter = wait_of(LONG_W'(cfg.clock_low_ticks));
      s.phase        = PH_BIT_HIGH;
    end
  end

  assign st_nxt  = s;
  assign bit_nxt = b;
  assign res     = '{clk_pin:      s.pin_clk,
                     data_pin:     s.pin_data,
                     latch_pin:    s.pin_le,
                     enable_pin:   s.pin_oe,
                     busy_res:     (s.phase != PH_IDLE),
                     done_res:     done,
                     completed_ok: ok};

endmodule

`default_nettype wire

// ===== rtl/core/lsd_seq.sv =====
// Sequencer datapath: input register, state registers and result register.
// Depends on lsd_pkg, lsd_if and lsd_step.
`timescale 1ns / 1ps
`default_nettype none

module lsd_seq #(
  parameter int SHIFT_BITS = 32
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire lsd_pkg::cfg_t cfg,
  lsd_in_if.sink      in_ch,
  lsd_out_if.source   out_ch
);
  import lsd_pkg::*;

  localparam int BIT_W = $clog2(SHIFT_BITS);

  logic             in_valid_r;
  in_item_t         in_item_r;
  logic             out_valid_r;
  out_item_t        out_item_r;
  seq_state_t       st_r;
  seq_state_t       st_nxt;
  logic [BIT_W-1:0] bit_r;
  logic [BIT_W-1:0] bit_nxt;
  out_item_t        res;
  logic             advance;
  logic             in_ready;

  // A held beat moves on when the result register is free or being drained.
  assign advance  = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready = !in_valid_r || advance;
  assign in_ch.ready = in_ready;

  lsd_step #(
    .SHIFT_BITS (SHIFT_BITS)
  ) u_step (
    .cfg     (cfg),
    .st      (st_r),
    .bit_idx (bit_r),
    .item    (in_item_r),
    .st_nxt  (st_nxt),
    .bit_nxt (bit_nxt),
    .res     (res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      in_item_r.op           <= in_ch.op;
      in_item_r.led_index    <= in_ch.led_index;
      in_item_r.oe_low_ticks <= in_ch.oe_low_ticks;
      in_item_r.repeat_mode  <= in_ch.repeat_mode;
      in_item_r.in_cradle    <= in_ch.in_cradle;
    end
  end

  // Sequencer state advances once per beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase         <= PH_IDLE;
      st_r.repeat_count  <= '0;
      st_r.wait_counter  <= '0;
      st_r.saved_led     <= '0;
      st_r.saved_oe_time <= '0;
      st_r.saved_scan    <= 1'b0;
      st_r.pin_clk       <= 1'b0;
      st_r.pin_data      <= 1'b0;
      st_r.pin_le        <= 1'b0;
      st_r.pin_oe        <= 1'b1;
      bit_r              <= '0;
    end else if (advance) begin
      st_r  <= st_nxt;
      bit_r <= bit_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.clk_pin      = out_item_r.clk_pin;
  assign out_ch.data_pin     = out_item_r.data_pin;
  assign out_ch.latch_pin    = out_item_r.latch_pin;
  assign out_ch.enable_pin   = out_item_r.enable_pin;
  assign out_ch.busy_res     = out_item_r.busy_res;
  assign out_ch.done_res     = out_item_r.done_res;
  assign out_ch.completed_ok = out_item_r.completed_ok;

endmodule

`default_nettype wire

// ===== rtl/core/led_driver_shift_sequencer.sv =====
// Top level of the LED driver shift sequencer: register bank and sequencer.
// Depends on lsd_pkg, lsd_if, lsd_cfg_regs and lsd_seq.
//
// Each input beat is either one time tick or a start command; every beat yields
// exactly one result beat with the four driver pin levels (clock, data, latch,
// output enable, active low) plus busy, done and completed flags. A start while
// a run is active counts as a plain tick. Beats flow at one per clock cycle while
// the receiver keeps the result channel ready: a beat passes through the input
// register and then the result register, with the sequencer's next-state logic
// between the two registers. Settings on the APB-style port (byte address 4 times
// the register index) must be written while no run is active.
`timescale 1ns / 1ps
`default_nettype none

module led_driver_shift_sequencer #(
  parameter int SHIFT_BITS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  lsd_in_if.sink                              in_ch,
  lsd_out_if.source                           out_ch,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [lsd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [lsd_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [lsd_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                cfg_pready
);
  import lsd_pkg::*;

  cfg_t cfg;

  lsd_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  lsd_seq #(
    .SHIFT_BITS (SHIFT_BITS)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// ===== tb/led_driver_shift_sequencer_test.sv =====
// Self-checking testbench for the LED driver shift sequencer: directed table, then random phases.
// Depends on lsd_pkg, lsd_if and the led_driver_shift_sequencer top level.
`timescale 1ns / 1ps

module led_driver_shift_sequencer_test;
  import lsd_pkg::*;

  localparam int SHIFT_BITS  = 32;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int MAX_REPORTS = 20;

  // Command codes carried in the op field.
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Data line bit positions: first LED bank and the stride to the second bank.
  localparam int DATA_ON_POS = 31;
  localparam int BANK_STRIDE = 10;

  localparam out_item_t PINS_IDLE = '{clk_pin: 1'b0, data_pin: 1'b0, latch_pin: 1'b0,
                                      enable_pin: 1'b1, busy_res: 1'b0, done_res: 1'b0,
                                      completed_ok: 1'b0};
  localparam out_item_t PINS_ABORT = '{clk_pin: 1'b0, data_pin: 1'b0, latch_pin: 1'b0,
                                       enable_pin: 1'b1, busy_res: 1'b0, done_res: 1'b1,
                                       completed_ok: 1'b0};

  // How a directed row is followed up: nothing, ticks to the end, or an abort at the next pass.
  typedef enum int {TAIL_NONE, TAIL_FINISH, TAIL_ABORT} tail_t;

  typedef struct {
    in_item_t  beat;
    bit        typed;
    out_item_t want;
    bit        new_timing;
    tail_t     tail;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  lsd_in_if  cmd_ch ();
  lsd_out_if pin_ch ();

  led_driver_shift_sequencer #(
    .SHIFT_BITS (SHIFT_BITS)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (cmd_ch),
    .out_ch      (pin_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Shadow copy of the register bank and of the sequencer state.
  cfg_t              timing;
  phase_t            sq_phase;
  int                sq_bit;
  logic [REPS_W-1:0] sq_reps_left;
  logic [LONG_W-1:0] sq_wait;
  logic [LED_W-1:0]  sq_led;
  logic [LONG_W-1:0] sq_oe_time;
  logic              sq_scan;
  logic              pn_clk, pn_data, pn_le, pn_oe;
  logic              fin_done, fin_ok;

  out_item_t pin_levels_due[$];
  dir_row_t  dir_rows[$];
  int        err_count;
  int        cycle_count;
  int        rcv_mode;
  int        src_burst_left;
  bit        src_gaps_on;

  // ---------------------------------------------------------------------------
  // Sequencer prediction.
  // ---------------------------------------------------------------------------

  // A zero delay still costs one tick.
  function automatic void load_wait(input logic [LONG_W-1:0] d);
    sq_wait = (d == '0) ? LONG_W'(1) : d;
  endfunction

  function automatic void end_run(input logic ok);
    sq_phase = PH_IDLE;
    sq_wait  = '0;
    fin_done = 1'b1;
    fin_ok   = ok;
  endfunction

  // Clock goes low and the data line changes at the two LED positions.
  function automatic void shift_bit_low();
    int b, led;
    b   = sq_bit;
    led = int'(sq_led);
    pn_clk = 1'b0;
    if (b == DATA_ON_POS - led || b == DATA_ON_POS - BANK_STRIDE - led) begin
      pn_data = 1'b1;
    end else if (b == DATA_ON_POS + 1 - led || b == DATA_ON_POS + 1 - BANK_STRIDE - led) begin
      pn_data = 1'b0;
    end
    load_wait({8'd0, timing.clock_low_ticks});
    sq_phase = PH_BIT_HIGH;
  endfunction

  // A pass begins unless the cradle flag is up.
  function automatic void start_pass(input logic cradle);
    if (cradle) begin
      end_run(1'b0);
    end else begin
      sq_bit = 0;
      shift_bit_low();
    end
  endfunction

  function automatic void take_action(input logic cradle);
    case (sq_phase)
      PH_BIT_LOW: begin
        shift_bit_low();
      end
      PH_BIT_HIGH: begin
        pn_clk = 1'b1;
        load_wait({8'd0, timing.clock_high_ticks});
        if (sq_bit + 1 >= SHIFT_BITS) begin
          sq_phase = PH_CLK_END;
        end else begin
          sq_bit   = sq_bit + 1;
          sq_phase = PH_BIT_LOW;
        end
      end
      PH_CLK_END: begin
        pn_clk = 1'b0;
        load_wait({8'd0, timing.clock_low_ticks});
        sq_phase = PH_LE_HIGH;
      end
      PH_LE_HIGH: begin
        pn_le = 1'b1;
        load_wait({8'd0, timing.clock_high_ticks});
        sq_phase = PH_LE_LOW;
      end
      PH_LE_LOW: begin
        pn_le = 1'b0;
        load_wait({8'd0, timing.latch_to_enable_ticks});
        sq_phase = PH_OE_LOW;
      end
      PH_OE_LOW: begin
        pn_oe = 1'b0;
        load_wait(sq_oe_time);
        sq_phase = PH_NEXT;
      end
      PH_NEXT: begin
        if (sq_reps_left != '0) begin
          sq_reps_left = sq_reps_left - REPS_W'(1);
          start_pass(cradle);
        end else if (sq_scan) begin
          pn_oe = 1'b1;
          load_wait(timing.gap_ticks);
          sq_phase = PH_FINISH;
        end else begin
          end_run(1'b1);
        end
      end
      default: begin
        end_run(1'b1);
      end
    endcase
  endfunction

  // Advances the shadow sequencer by one beat and returns the pin levels it leaves.
  function automatic out_item_t step_sequencer(input in_item_t it);
    out_item_t        r;
    logic [REPS_W-1:0] reps;
    fin_done = 1'b0;
    fin_ok   = 1'b0;
    if (sq_phase == PH_IDLE) begin
      if (it.op == OP_START) begin
        sq_led     = it.led_index;
        sq_oe_time = it.oe_low_ticks;
        sq_scan    = it.repeat_mode;
        reps = sq_scan ? timing.scan_repeats : REPS_W'(1);
        if (reps == '0) begin
          reps = REPS_W'(1);
        end
        sq_reps_left = reps - REPS_W'(1);
        start_pass(it.in_cradle);
      end
    end else begin
      if (sq_wait != '0) begin
        sq_wait = sq_wait - LONG_W'(1);
      end
      if (sq_wait == '0) begin
        take_action(it.in_cradle);
      end
    end
    r.clk_pin      = pn_clk;
    r.data_pin     = pn_data;
    r.latch_pin    = pn_le;
    r.enable_pin   = pn_oe;
    r.busy_res     = (sq_phase != PH_IDLE);
    r.done_res     = fin_done;
    r.completed_ok = fin_ok;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, cycle limit and result checking.
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input logic got, input logic exp);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("cycle %0d: %s is %b, expected %b", cycle_count, what, got, exp);
    end
  endtask

  // Receiver stalls follow a mode that is drawn anew whenever the low byte of the cycle count is zero.
  always @(posedge clk) begin
    if (cycle_count[7:0] == 8'd0) begin
      rcv_mode <= int'($urandom_range(0, 3));
    end
    case (rcv_mode)
      0: pin_ch.ready <= 1'b1;
      1: pin_ch.ready <= ($urandom_range(0, 3) != 0);
      2: pin_ch.ready <= (cycle_count[2:0] != 3'd5) && (cycle_count[4:3] != 2'd0);
      default: pin_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Every result beat is compared with the oldest expected pin levels.
  always @(posedge clk) begin : check_out
    out_item_t got, exp;
    if (rst_n && pin_ch.valid && pin_ch.ready) begin
      got.clk_pin      = pin_ch.clk_pin;
      got.data_pin     = pin_ch.data_pin;
      got.latch_pin    = pin_ch.latch_pin;
      got.enable_pin   = pin_ch.enable_pin;
      got.busy_res     = pin_ch.busy_res;
      got.done_res     = pin_ch.done_res;
      got.completed_ok = pin_ch.completed_ok;
      if (pin_levels_due.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS) begin
          $display("cycle %0d: result beat with nothing expected", cycle_count);
        end
      end else begin
        exp = pin_levels_due.pop_front();
        if (got.clk_pin !== exp.clk_pin) flag_mismatch("clk_pin", got.clk_pin, exp.clk_pin);
        if (got.data_pin !== exp.data_pin) flag_mismatch("data_pin", got.data_pin, exp.data_pin);
        if (got.latch_pin !== exp.latch_pin) begin
          flag_mismatch("latch_pin", got.latch_pin, exp.latch_pin);
        end
        if (got.enable_pin !== exp.enable_pin) begin
          flag_mismatch("enable_pin", got.enable_pin, exp.enable_pin);
        end
        if (got.busy_res !== exp.busy_res) flag_mismatch("busy_res", got.busy_res, exp.busy_res);
        if (got.done_res !== exp.done_res) flag_mismatch("done_res", got.done_res, exp.done_res);
        if (got.completed_ok !== exp.completed_ok) begin
          flag_mismatch("completed_ok", got.completed_ok, exp.completed_ok);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------

  // Drives one command beat, waits for it to be taken and queues its expected result.
  task automatic send_beat(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t pred;
    if (src_gaps_on && src_burst_left == 0) begin
      src_burst_left = int'($urandom_range(1, 32));
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    if (src_burst_left > 0) begin
      src_burst_left--;
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.op           <= it.op;
    cmd_ch.led_index    <= it.led_index;
    cmd_ch.oe_low_ticks <= it.oe_low_ticks;
    cmd_ch.repeat_mode  <= it.repeat_mode;
    cmd_ch.in_cradle    <= it.in_cradle;
    do @(posedge clk); while (!cmd_ch.ready);
    pred = step_sequencer(it);
    pin_levels_due.push_back(typed ? want : pred);
  endtask

  // Holds the sender off until every expected result has come back.
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pin_levels_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // One register write: setup phase, access phase, then an idle phase on the bus.
  task automatic cfg_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_CLK_HIGH:  timing.clock_high_ticks      = val[TICK_W-1:0];
      REG_CLK_LOW:   timing.clock_low_ticks       = val[TICK_W-1:0];
      REG_LE_TO_OE:  timing.latch_to_enable_ticks = val[TICK_W-1:0];
      REG_GAP:       timing.gap_ticks             = val[LONG_W-1:0];
      REG_SCAN_REPS: timing.scan_repeats          = val[REPS_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_timing(input logic [TICK_W-1:0] hi_ticks, input logic [TICK_W-1:0] lo_ticks,
                            input logic [TICK_W-1:0] le_ticks, input logic [LONG_W-1:0] gap,
                            input logic [REPS_W-1:0] reps);
    cfg_write(REG_CLK_HIGH, CFG_DATA_W'(hi_ticks));
    cfg_write(REG_CLK_LOW, CFG_DATA_W'(lo_ticks));
    cfg_write(REG_LE_TO_OE, CFG_DATA_W'(le_ticks));
    cfg_write(REG_GAP, CFG_DATA_W'(gap));
    cfg_write(REG_SCAN_REPS, CFG_DATA_W'(reps));
  endtask

  // Ticks with random content until the run ends, optionally aborting at the next pass.
  task automatic run_to_idle(input bit abort_next);
    in_item_t b;
    while (sq_phase != PH_IDLE) begin
      b.op           = OP_TICK;
      b.led_index    = LED_W'($urandom);
      b.oe_low_ticks = LONG_W'($urandom);
      b.repeat_mode  = 1'($urandom);
      b.in_cradle    = abort_next && sq_phase == PH_NEXT && sq_wait <= LONG_W'(1)
                       && sq_reps_left != '0;
      send_beat(b, 1'b0, PINS_IDLE);
    end
  endtask

  // Mostly well-formed starts with random content while idle, ticks while busy.
  function automatic in_item_t random_beat(input bit abort_only);
    in_item_t b;
    b.op           = OP_TICK;
    b.led_index    = LED_W'($urandom);
    b.oe_low_ticks = LONG_W'($urandom);
    b.repeat_mode  = 1'($urandom);
    b.in_cradle    = ($urandom_range(0, 99) < 3);
    if (sq_phase == PH_IDLE) begin
      if ($urandom_range(0, 3) != 0) begin
        b.op        = OP_START;
        b.led_index = ($urandom_range(0, 7) == 0) ? LED_W'($urandom_range(22, 31))
                                                  : LED_W'($urandom_range(0, 21));
        b.in_cradle = abort_only || ($urandom_range(0, 9) == 0);
        if (!b.in_cradle) begin
          b.oe_low_ticks = ($urandom_range(0, 9) == 0) ? LONG_W'($urandom_range(0, 400))
                                                       : LONG_W'($urandom_range(0, 20));
        end
      end
    end else begin
      if ($urandom_range(0, 19) == 0) begin
        b.op = OP_START;
      end
      // Raise the cradle flag often on the beat where a new pass would begin.
      if (sq_phase == PH_NEXT && sq_wait <= LONG_W'(1) && sq_reps_left != '0) begin
        b.in_cradle = ($urandom_range(0, 3) == 0);
      end
    end
    return b;
  endfunction

  // One random phase: a number of beats that do something, then run out and drain.
  task automatic run_phase(input int quota, input bit abort_only);
    in_item_t b;
    int       busy_beats;
    bit       counts;
    busy_beats  = 0;
    src_gaps_on = ($urandom_range(0, 2) != 0);
    while (busy_beats < quota) begin
      b = random_beat(abort_only);
      counts = (sq_phase != PH_IDLE) || (b.op == OP_START);
      if ($urandom_range(0, 299) == 0) begin
        settle();
      end
      send_beat(b, 1'b0, PINS_IDLE);
      if (counts) begin
        busy_beats++;
      end
    end
    run_to_idle(1'b0);
    settle();
  endtask

  function automatic void add_row(input tail_t tail, input bit new_timing, input logic op,
                                  input logic [LED_W-1:0] led, input logic [LONG_W-1:0] oe,
                                  input logic scan, input logic cradle, input bit typed,
                                  input out_item_t want);
    dir_row_t row;
    row.beat.op           = op;
    row.beat.led_index    = led;
    row.beat.oe_low_ticks = oe;
    row.beat.repeat_mode  = scan;
    row.beat.in_cradle    = cradle;
    row.typed             = typed;
    row.want              = want;
    row.new_timing        = new_timing;
    row.tail              = tail;
    dir_rows.push_back(row);
  endfunction

  initial begin
    rst_n = 1'b0;
    cmd_ch.valid        = 1'b0;
    cmd_ch.op           = OP_TICK;
    cmd_ch.led_index    = '0;
    cmd_ch.oe_low_ticks = '0;
    cmd_ch.repeat_mode  = 1'b0;
    cmd_ch.in_cradle    = 1'b0;
    pin_ch.ready        = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    err_count      = 0;
    cycle_count    = 0;
    rcv_mode       = 0;
    src_burst_left = 0;
    src_gaps_on    = 1'b1;

    // Shadow state at reset.
    timing.clock_high_ticks      = CLK_HIGH_RST;
    timing.clock_low_ticks       = CLK_LOW_RST;
    timing.latch_to_enable_ticks = LE_TO_OE_RST;
    timing.gap_ticks             = GAP_RST;
    timing.scan_repeats          = REPEATS_RST;
    sq_phase     = PH_IDLE;
    sq_bit       = 0;
    sq_reps_left = '0;
    sq_wait      = '0;
    sq_led       = '0;
    sq_oe_time   = '0;
    sq_scan      = 1'b0;
    pn_clk  = 1'b0;
    pn_data = 1'b0;
    pn_le   = 1'b0;
    pn_oe   = 1'b1;

    // Directed table. Under reset timing only idle ticks and cradle aborts are sent.
    add_row(TAIL_NONE, 1'b0, OP_TICK, 5'd31, 24'hFFFFFF, 1'b1, 1'b1, 1'b1, PINS_IDLE);
    add_row(TAIL_NONE, 1'b0, OP_START, 5'd21, 24'hFFFFFF, 1'b1, 1'b1, 1'b1, PINS_ABORT);
    add_row(TAIL_NONE, 1'b0, OP_START, 5'd0, 24'h000000, 1'b0, 1'b1, 1'b1, PINS_ABORT);
    add_row(TAIL_NONE, 1'b0, OP_TICK, 5'd0, 24'h000000, 1'b0, 1'b0, 1'b1, PINS_IDLE);
    // Fast timing from here: single pass with a zero enable time, LED 0 leaves data high.
    add_row(TAIL_FINISH, 1'b1, OP_START, 5'd0, 24'd0, 1'b0, 1'b0, 1'b0, PINS_IDLE);
    // Highest LED in range, then a start while busy that must act as a tick.
    add_row(TAIL_NONE, 1'b0, OP_START, 5'd21, 24'd3, 1'b0, 1'b0, 1'b0, PINS_IDLE);
    add_row(TAIL_NONE, 1'b0, OP_START, 5'd31, 24'hFFFFFF, 1'b1, 1'b1, 1'b0, PINS_IDLE);
    add_row(TAIL_FINISH, 1'b0, OP_TICK, 5'd0, 24'd0, 1'b0, 1'b0, 1'b0, PINS_IDLE);
    // LED indexes past the range, where one bank position never matches.
    add_row(TAIL_FINISH, 1'b0, OP_START, 5'd31, 24'd2, 1'b0, 1'b0, 1'b0, PINS_IDLE);
    add_row(TAIL_FINISH, 1'b0, OP_START, 5'd22, 24'd1, 1'b0, 1'b0, 1'b0, PINS_IDLE);
    // Scan with LED 0: the data line stays high into the second pass.
    add_row(TAIL_FINISH, 1'b0, OP_START, 5'd0, 24'd1, 1'b1, 1'b0, 1'b0, PINS_IDLE);
    // Scan aborted by the cradle flag at the start of the second pass.
    add_row(TAIL_ABORT, 1'b0, OP_START, 5'd7, 24'd1, 1'b1, 1'b0, 1'b0, PINS_IDLE);
    add_row(TAIL_NONE, 1'b0, OP_TICK, 5'd0, 24'd0, 1'b0, 1'b0, 1'b0, PINS_IDLE);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].new_timing) begin
        settle();
        set_timing(16'd1, 16'd1, 16'd0, 24'd0, 4'd2);
      end
      send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
      if (dir_rows[i].tail != TAIL_NONE) begin
        run_to_idle(dir_rows[i].tail == TAIL_ABORT);
      end
    end
    settle();

    // Random phases: shortest delays, zero registers, a three-pass scan, largest values
    // with aborts only, a long latch-to-enable delay, a long gap, then a random timing.
    set_timing(16'd1, 16'd1, 16'd0, 24'd0, 4'd1);
    run_phase(60, 1'b0);
    set_timing(16'd0, 16'd0, 16'd0, 24'd0, 4'd0);
    run_phase(60, 1'b0);
    set_timing(16'd1, 16'd1, 16'd2, 24'd5, 4'd3);
    run_phase(40, 1'b0);
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 4'd15);
    run_phase(40, 1'b1);
    set_timing(16'd1, 16'd1, 16'd60, 24'd3, 4'd1);
    run_phase(20, 1'b0);
    set_timing(16'd1, 16'd1, 16'd1, 24'd60, 4'd2);
    run_phase(20, 1'b0);
    set_timing(TICK_W'($urandom_range(0, 1)), TICK_W'($urandom_range(0, 1)),
               TICK_W'($urandom_range(0, 4)), LONG_W'($urandom_range(0, 20)),
               REPS_W'($urandom_range(0, 2)));
    run_phase(40, 1'b0);

    // Wait for the last results to drain, then give the verdict.
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pin_levels_due.size() != 0);
    repeat (8) @(posedge clk);
    if (err_count == 0 && pin_levels_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
